@@ rtl/kpn_pkg.sv @@
// shared types, constants and key table for the keypad number entry block
package kpn_pkg;

  // digit store depth
  localparam int MAX_DIGITS = 9;

  // counter holds 0..MAX_DIGITS, index addresses 0..MAX_DIGITS-1
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // field widths
  localparam int NIB_W   = 4;
  localparam int CODE_W  = 8;
  localparam int ACT_W   = 2;
  localparam int VALUE_W = 30;
  localparam int HELD_W  = 4;
  localparam int DIGIT_W = 4;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // value saturation limit and digits_held limit
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [HELD_W-1:0]  HELD_MAX  = {HELD_W{1'b1}};

  // display action codes
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ECHO = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BACK = 2'd2;

  // special key characters
  localparam logic [CODE_W-1:0] KEY_CLEAR = 8'h43;  // 'C'
  localparam logic [CODE_W-1:0] KEY_ENTER = 8'h3D;  // '='
  localparam logic [CODE_W-1:0] KEY_ZERO  = 8'h30;  // '0'
  localparam logic [CODE_W-1:0] KEY_NINE  = 8'h39;  // '9'
  localparam logic [CODE_W-1:0] KEY_NONE  = 8'h00;

  // located key handed from the decoder to the controller
  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } key_t;

  // accumulator handshake with the controller
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } acc_cmd_t;

  // key table lookup, row and column 0..3
  function automatic logic [CODE_W-1:0] key_char(input logic [1:0] row, input logic [1:0] col);
    logic [CODE_W-1:0] c;
    c = KEY_NONE;
    case ({row, col})
      4'h0: c = 8'h37;  // 7
      4'h1: c = 8'h38;  // 8
      4'h2: c = 8'h39;  // 9
      4'h3: c = 8'h2F;  // /
      4'h4: c = 8'h34;  // 4
      4'h5: c = 8'h35;  // 5
      4'h6: c = 8'h36;  // 6
      4'h7: c = 8'h2A;  // *
      4'h8: c = 8'h31;  // 1
      4'h9: c = 8'h32;  // 2
      4'hA: c = 8'h33;  // 3
      4'hB: c = 8'h2D;  // -
      4'hC: c = 8'h43;  // C
      4'hD: c = 8'h30;  // 0
      4'hE: c = 8'h3D;  // =
      4'hF: c = 8'h2B;  // +
      default: c = KEY_NONE;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/kpn_decode.sv @@
// locates the pressed key from the scanned column nibbles and maps it to a character
module kpn_decode (
  input  logic [kpn_pkg::NIB_W-1:0] cols_row0,
  input  logic [kpn_pkg::NIB_W-1:0] cols_row1,
  input  logic [kpn_pkg::NIB_W-1:0] cols_row2,
  input  logic [kpn_pkg::NIB_W-1:0] cols_row3,
  input  logic [kpn_pkg::NIB_W-1:0] cols_all_low,
  output kpn_pkg::key_t             key
);
  import kpn_pkg::*;

  logic [1:0] row;
  logic [1:0] col;
  logic       row_ok;
  logic       col_ok;

  // first row with any column pulled low
  always_comb begin
    row    = 2'd0;
    row_ok = 1'b1;
    if (cols_row0 != 4'hF) begin
      row = 2'd0;
    end else if (cols_row1 != 4'hF) begin
      row = 2'd1;
    end else if (cols_row2 != 4'hF) begin
      row = 2'd2;
    end else if (cols_row3 != 4'hF) begin
      row = 2'd3;
    end else begin
      row_ok = 1'b0;
    end
  end

  // first low column of the all-rows sample
  always_comb begin
    col    = 2'd0;
    col_ok = 1'b1;
    if (!cols_all_low[0]) begin
      col = 2'd0;
    end else if (!cols_all_low[1]) begin
      col = 2'd1;
    end else if (!cols_all_low[2]) begin
      col = 2'd2;
    end else if (!cols_all_low[3]) begin
      col = 2'd3;
    end else begin
      col_ok = 1'b0;
    end
  end

  // table lookup, zero code when nothing was located
  always_comb begin
    key.found = row_ok && col_ok;
    key.code  = (row_ok && col_ok) ? key_char(row, col) : KEY_NONE;
  end

endmodule

@@ rtl/kpn_accum.sv @@
// decimal accumulator: folds one stored digit per cycle into value*10+digit
module kpn_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kpn_pkg::acc_cmd_t           cmd,
  input  logic [kpn_pkg::DIGIT_W-1:0] digit,
  output logic [kpn_pkg::IDX_W-1:0]   digit_idx,
  output logic                        done,
  output logic [kpn_pkg::VALUE_W-1:0] value
);
  import kpn_pkg::*;

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [VALUE_W+3:0] prod;

  // times ten as two shifted adds, plus the digit
  assign prod = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0} +
                {{VALUE_W{1'b0}}, digit};

  // store read address for the coming cycle, the digit arrives registered
  assign digit_idx = idx_nxt[IDX_W-1:0];
  assign done      = busy_r && (idx_r == count_r);
  assign value     = value_r;

  // iteration control
  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    value_nxt = value_r;
    if (cmd.start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      count_nxt = cmd.count;
      value_nxt = '0;
    end else if (busy_r) begin
      if (idx_r == count_r) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        value_nxt = (prod > {4'b0000, VALUE_MAX}) ? VALUE_MAX : prod[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    idx_r   <= idx_nxt;
    count_r <= count_nxt;
    value_r <= value_nxt;
  end

endmodule

@@ rtl/keypad_number_entry.sv @@
// top level of the keypad number entry block: controller, digit store and result register
//
// One input beat is one key press; one result beat comes out for every press. A digit,
// 'C', any other key or an unlocated press passes from S_IDLE through S_EXEC to S_PUT,
// which loads the result register. '=' goes through S_ACC between S_EXEC and S_PUT, where
// the accumulator folds one stored digit per cycle into value*10+digit. The result
// register frees the input side: a new press is taken while the previous result waits.
module keypad_number_entry (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cols_row0[3:0], cols_row1[7:4], cols_row2[11:8], cols_row3[15:12],
  // cols_all_low[19:16], zero [23:20]
  input  logic [kpn_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // key_found[0], key_code[8:1], display_action[10:9], entry_done[11],
  // number_value[41:12], digits_held[45:42], zero [47:46]
  output logic [kpn_pkg::OUT_DATA_W-1:0] out_tdata
);
  import kpn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ACC, S_PUT} state_t;

  state_t              state_r, state_nxt;
  key_t                key_in;
  key_t                key_r, key_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic                done_r, done_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [DIGIT_W-1:0]  store [MAX_DIGITS];
  logic [DIGIT_W-1:0]  digit_r;
  logic                store_we;
  acc_cmd_t            acc_cmd;
  logic [IDX_W-1:0]    acc_idx;
  logic                acc_done;
  logic [VALUE_W-1:0]  acc_value;
  logic                is_digit;
  logic [HELD_W-1:0]   held;

  // key locate and table lookup
  kpn_decode u_decode (
    .cols_row0    (in_tdata[3:0]),
    .cols_row1    (in_tdata[7:4]),
    .cols_row2    (in_tdata[11:8]),
    .cols_row3    (in_tdata[15:12]),
    .cols_all_low (in_tdata[19:16]),
    .key          (key_in)
  );

  // enter key value accumulation
  kpn_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (acc_cmd),
    .digit     (digit_r),
    .digit_idx (acc_idx),
    .done      (acc_done),
    .value     (acc_value)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign is_digit = key_r.found && (key_r.code >= KEY_ZERO) && (key_r.code <= KEY_NINE);
  assign store_we = (state_r == S_EXEC) && is_digit && (32'(cnt_r) < MAX_DIGITS);
  assign held     = (32'(cnt_r) > 32'(HELD_MAX)) ? HELD_MAX : HELD_W'(cnt_r);

  always_comb begin
    acc_cmd.start = (state_r == S_EXEC) && key_r.found && (key_r.code == KEY_ENTER);
    acc_cmd.count = cnt_r;
  end

  // controller next state
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    done_nxt      = done_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt   = key_in;
          act_nxt   = ACT_NONE;
          done_nxt  = 1'b0;
          val_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_PUT;
        if (is_digit) begin
          if (32'(cnt_r) < MAX_DIGITS) begin
            cnt_nxt = cnt_r + 1'b1;
            act_nxt = ACT_ECHO;
          end
        end else if (key_r.found && (key_r.code == KEY_CLEAR)) begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
            act_nxt = ACT_BACK;
          end
        end else if (key_r.found && (key_r.code == KEY_ENTER)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (acc_done) begin
          done_nxt  = 1'b1;
          val_nxt   = acc_value;
          cnt_nxt   = '0;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        // load the result register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, held, val_r, done_r, act_r, key_r.code, key_r.found};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    act_r      <= act_nxt;
    done_r     <= done_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  // digit store, written at the current count, read through a register ahead of use by the accumulator
  always_ff @(posedge clk) begin
    if (store_we) begin
      store[cnt_r[IDX_W-1:0]] <= key_r.code[DIGIT_W-1:0];
    end
    digit_r <= store[acc_idx];
  end

endmodule

@@ dv/keypad_number_entry_chk.sv @@
// stream monitor, key press predictor and result comparator for keypad_number_entry
module keypad_number_entry_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [kpn_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [kpn_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             pending
);
  import kpn_pkg::*;

  // key characters, row-major from row 0 col 0 in the lowest byte
  localparam logic [16*CODE_W-1:0] KEY_GRID = {"+=0C", "-321", "*654", "/987"};

  typedef struct packed {
    logic               key_found;
    logic [CODE_W-1:0]  key_code;
    logic [ACT_W-1:0]   display_action;
    logic               entry_done;
    logic [VALUE_W-1:0] number_value;
    logic [HELD_W-1:0]  digits_held;
  } outcome_t;

  // entered digits and how many are held
  logic [DIGIT_W-1:0] digit_bank [MAX_DIGITS];
  int                 held_count;

  outcome_t outcome_q [$];

  // locate the key, update the entered number and build the result beat
  function automatic outcome_t key_outcome(input logic [IN_DATA_W-1:0] beat);
    outcome_t    o;
    int          row;
    int          col;
    logic [7:0]  ch;
    longint      acc;
    o   = '0;
    row = 4;
    col = 4;
    // first row with any low column wins
    for (int i = 3; i >= 0; i--) begin
      if (beat[NIB_W*i +: NIB_W] != 4'hF) row = i;
    end
    // first low bit of the all-rows sample
    for (int i = 3; i >= 0; i--) begin
      if (!beat[4*NIB_W + i]) col = i;
    end
    if (row < 4 && col < 4) begin
      o.key_found = 1'b1;
      ch          = KEY_GRID[(row*4 + col)*CODE_W +: CODE_W];
      o.key_code  = ch;
      if (ch >= KEY_ZERO && ch <= KEY_NINE) begin
        // digits beyond a full store are dropped
        if (held_count < MAX_DIGITS) begin
          digit_bank[held_count] = DIGIT_W'(ch - KEY_ZERO);
          held_count++;
          o.display_action = ACT_ECHO;
        end
      end else if (ch == KEY_CLEAR) begin
        if (held_count > 0) begin
          held_count--;
          o.display_action = ACT_BACK;
        end
      end else if (ch == KEY_ENTER) begin
        o.entry_done = 1'b1;
        acc = 0;
        for (int i = 0; i < held_count; i++) begin
          acc = acc * 10 + digit_bank[i];
          if (acc > VALUE_MAX) acc = VALUE_MAX;
        end
        o.number_value = VALUE_W'(acc);
        held_count = 0;
      end
    end
    o.digits_held = (held_count > HELD_MAX) ? HELD_MAX : HELD_W'(held_count);
    return o;
  endfunction

  task automatic flag_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // watch both channels, results are matched before the same-edge press is queued
  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_n) begin
      held_count = 0;
      mismatches = 0;
      outcome_q.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.key_found      = out_tdata[0];
        seen.key_code       = out_tdata[8:1];
        seen.display_action = out_tdata[10:9];
        seen.entry_done     = out_tdata[11];
        seen.number_value   = out_tdata[41:12];
        seen.digits_held    = out_tdata[45:42];
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with no press waiting, expected none actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          flag_field("key_found", want.key_found, seen.key_found);
          flag_field("key_code", want.key_code, seen.key_code);
          flag_field("display_action", want.display_action, seen.display_action);
          flag_field("entry_done", want.entry_done, seen.entry_done);
          flag_field("number_value", want.number_value, seen.number_value);
          flag_field("digits_held", want.digits_held, seen.digits_held);
        end
      end
      if (in_tvalid && in_tready) outcome_q.push_back(key_outcome(in_tdata));
      pending <= outcome_q.size();
    end
  end

endmodule

@@ dv/keypad_number_entry_tb.sv @@
// testbench top for keypad_number_entry: clock, reset, key press stimulus and verdict
module keypad_number_entry_tb;

  import kpn_pkg::*;

  // key positions as {row, col}
  localparam logic [3:0] KEY_POS_CLEAR = 4'hC;
  localparam logic [3:0] KEY_POS_ENTER = 4'hE;
  localparam logic [1:0] OP_COL        = 2'd3;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 1200;
  localparam int HOLD_LEN    = 200;
  localparam int DRAIN       = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int presses_sent = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  keypad_number_entry DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  keypad_number_entry_chk chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side ready, with one long hold-off while presses keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && presses_sent >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_LEN;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // press at {row, col}: earlier rows idle, later rows and high columns random
  function automatic logic [IN_DATA_W-1:0] key_beat(input logic [3:0] pos);
    logic [IN_DATA_W-1:0] beat;
    logic [3:0]           cols;
    int                   row;
    int                   col;
    row  = pos[3:2];
    col  = pos[1:0];
    beat = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < row) beat[NIB_W*i +: NIB_W] = 4'hF;
      else if (i == row) beat[NIB_W*i +: NIB_W] = 4'($urandom_range(0, 14));
      else beat[NIB_W*i +: NIB_W] = 4'($urandom_range(0, 15));
    end
    cols = 4'($urandom_range(0, 15));
    cols = cols | 4'((1 << col) - 1);
    cols[col] = 1'b0;
    beat[4*NIB_W +: NIB_W] = cols;
    return beat;
  endfunction

  task automatic offer_press(input logic [IN_DATA_W-1:0] beat);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    presses_sent++;
  endtask

  task automatic press_key(input logic [3:0] pos);
    offer_press(key_beat(pos));
  endtask

  task automatic press_digit(input int d);
    if (d == 0) press_key(4'hD);
    else press_key({2'(2 - (d - 1) / 3), 2'((d - 1) % 3)});
  endtask

  // one random burst of key presses
  task automatic run_sequence();
    int kind;
    int r;
    logic [IN_DATA_W-1:0] beat;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // a number entry with a few corrections, closed by enter
      repeat ($urandom_range(0, 11)) begin
        r = $urandom_range(0, 99);
        if (r < 8) press_key(KEY_POS_CLEAR);
        else if (r < 12) press_key({2'($urandom_range(0, 3)), OP_COL});
        else press_digit($urandom_range(0, 9));
      end
      press_key(KEY_POS_ENTER);
    end else if (kind < 75) begin
      // digits and backspaces left open
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 2) == 0) press_key(KEY_POS_CLEAR);
        else press_digit($urandom_range(0, 9));
      end
    end else if (kind < 90) begin
      press_key(4'($urandom_range(0, 15)));
    end else begin
      // noise: unlocated presses and raw samples
      beat = '0;
      beat[4*NIB_W-1:0] = 16'($urandom_range(0, 65535));
      beat[4*NIB_W +: NIB_W] = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 2);
      if (r == 0) beat[4*NIB_W-1:0] = 16'hFFFF;
      else if (r == 1) beat[4*NIB_W +: NIB_W] = 4'hF;
      offer_press(beat);
    end
  endtask

  initial begin
    src_idle_pct  = 37;
    sink_idle_pct = 71;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // enter and backspace on an empty store
    press_key(KEY_POS_ENTER);
    press_key(KEY_POS_CLEAR);
    // no row found, then no column found
    offer_press(24'h00FFFF);
    offer_press(24'h0F0000);
    // every line low selects the top-left key
    offer_press('0);
    // walk the whole pad: fills the store, drops a digit, backspaces, enters
    for (int p = 0; p < 16; p++) press_key(4'(p));
    // largest nine-digit value
    repeat (MAX_DIGITS) press_digit(9);
    press_key(KEY_POS_ENTER);

    while (presses_sent < 540) run_sequence();
    src_idle_pct  = 71;
    sink_idle_pct = 37;
    while (presses_sent < 1050) run_sequence();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (presses_sent < 1550) run_sequence();
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kpn_pkg.sv
rtl/kpn_decode.sv
rtl/kpn_accum.sv
rtl/keypad_number_entry.sv
dv/keypad_number_entry_chk.sv
dv/keypad_number_entry_tb.sv
